// ===== rtl/mbss_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and helpers of the masked byte signature scanner.
// No dependencies.
package mbss_pkg;

	localparam int PATTERN_BYTES = 16;
	localparam int ADDRESS_BITS  = 48;

	localparam int WIN_DEPTH = PATTERN_BYTES - 1;
	localparam int LEN_W     = $clog2(PATTERN_BYTES + 1);
	localparam int FILL_W    = $clog2(PATTERN_BYTES);

	localparam int CFG_DATA_W  = 64;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_LEN_W   = 5;
	localparam int CNT_W       = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_PAT_LOW  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PAT_HIGH = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_CARE     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_LEN      = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_LIMIT    = 3'd4;

	localparam logic [CFG_LEN_W-1:0] LEN_RESET = CFG_LEN_W'(16);

	typedef logic [PATTERN_BYTES-1:0][7:0] byte_seq_t;
	typedef logic [WIN_DEPTH-1:0][7:0]     byte_win_t;

	// settings seen by the compare stage
	typedef struct packed {
		byte_seq_t                pattern;
		logic [PATTERN_BYTES-1:0] care;
		logic [LEN_W-1:0]         len;
	} match_cfg_t;

	// pattern length clamped to 1..PATTERN_BYTES
	function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_LEN_W-1:0] raw);
		logic [LEN_W-1:0] r;
		if (raw == '0) begin
			r = LEN_W'(1);
		end else if (raw > CFG_LEN_W'(PATTERN_BYTES)) begin
			r = LEN_W'(PATTERN_BYTES);
		end else begin
			r = LEN_W'(raw);
		end
		return r;
	endfunction

endpackage

// ===== rtl/mbss_match.sv =====
`timescale 1ns / 1ps
// Masked compare of the byte window against the signature.
// Depends on mbss_pkg.
module mbss_match (
	input  mbss_pkg::byte_seq_t  seq,
	input  mbss_pkg::match_cfg_t cfg,
	output logic                 hit
);

	logic [mbss_pkg::PATTERN_BYTES-1:0] miss;

	// seq[0] is the newest byte; pattern byte i lines up with seq[len-1-i]
	always_comb begin
		for (int i = 0; i < mbss_pkg::PATTERN_BYTES; i++) begin
			logic [mbss_pkg::LEN_W-1:0] back;
			back = cfg.len - mbss_pkg::LEN_W'(1) - mbss_pkg::LEN_W'(i);
			miss[i] = (mbss_pkg::LEN_W'(i) < cfg.len) && cfg.care[i] &&
				(seq[back[mbss_pkg::FILL_W-1:0]] != cfg.pattern[i]);
		end
	end

	assign hit = ~|miss;

endmodule

// ===== rtl/masked_byte_signature_scanner.sv =====
`timescale 1ns / 1ps
// Masked byte signature scanner: top level.
// Depends on mbss_pkg and mbss_match.
//
// Usage:
//  Input channel byte_valid/byte_ready carries one memory byte per item with
//  its address and a first_of_region flag that restarts the scan.
//  Output channel match_valid/match_ready carries one item per matching
//  window: start address, match ordinal and a limit-reached flag.
//  Bytes with no match produce no output item.
//  Configuration is a write-only port (cfg_write_en, cfg_index, cfg_data),
//  to be written only while the block is idle; the block doesn't check.
//  Timing: a byte is registered on accept in the input register and is
//  compared from there; its match is loaded into the output register when
//  the compare stage advances, which a receiver stall can hold off.
//  Throughput: one byte per cycle unless the receiver stalls; set by the
//  single compare stage between the input register and the output register.
//  When the receiver stalls with a match pending, the compare stage holds
//  its byte and byte_ready drops; nothing is dropped.
//  Reset clears the window, count, stop flag, both valid flags and the
//  configuration registers (pattern length resets to 16).
module masked_byte_signature_scanner (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                byte_valid,
	output logic                                byte_ready,
	input  logic [7:0]                          data_byte,
	input  logic [mbss_pkg::ADDRESS_BITS-1:0]   byte_address,
	input  logic                                first_of_region,
	output logic                                match_valid,
	input  logic                                match_ready,
	output logic [mbss_pkg::ADDRESS_BITS-1:0]   match_address,
	output logic [mbss_pkg::CNT_W-1:0]          match_number,
	output logic                                limit_reached,
	input  logic                                cfg_write_en,
	input  logic [mbss_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [mbss_pkg::CFG_DATA_W-1:0]     cfg_data
);

	// configuration registers
	logic [63:0]                      pat_low_q;
	logic [63:0]                      pat_high_q;
	logic [mbss_pkg::PATTERN_BYTES-1:0] care_q;
	logic [mbss_pkg::CFG_LEN_W-1:0]   len_q;
	logic [mbss_pkg::CNT_W-1:0]       limit_q;

	// input stage
	logic                              valid_s1;
	logic [7:0]                        data_s1;
	logic [mbss_pkg::ADDRESS_BITS-1:0] addr_s1;
	logic                              first_s1;

	// scan state
	mbss_pkg::byte_win_t          win_q;
	logic [mbss_pkg::FILL_W-1:0]  fill_q;
	logic [mbss_pkg::CNT_W-1:0]   cnt_q;
	logic                         stop_q;

	// compare stage
	logic                         advance;
	mbss_pkg::byte_seq_t          seq;
	mbss_pkg::match_cfg_t         mcfg;
	logic                         hit_raw;
	logic                         hit;
	logic [mbss_pkg::FILL_W-1:0]  fill_base;
	logic [mbss_pkg::FILL_W-1:0]  fill_next;
	logic [mbss_pkg::CNT_W-1:0]   cnt_base;
	logic [mbss_pkg::CNT_W-1:0]   cnt_inc;
	logic                         stop_base;
	logic                         at_limit;
	logic                         fill_ok;

	// output register
	logic                              out_valid_q;
	logic [mbss_pkg::ADDRESS_BITS-1:0] out_addr_q;
	logic [mbss_pkg::CNT_W-1:0]        out_num_q;
	logic                              out_lim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			care_q     <= '0;
			len_q      <= mbss_pkg::LEN_RESET;
			limit_q    <= '0;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				mbss_pkg::REG_PAT_LOW:  pat_low_q  <= cfg_data;
				mbss_pkg::REG_PAT_HIGH: pat_high_q <= cfg_data;
				mbss_pkg::REG_CARE:     care_q     <= cfg_data[mbss_pkg::PATTERN_BYTES-1:0];
				mbss_pkg::REG_LEN:      len_q      <= cfg_data[mbss_pkg::CFG_LEN_W-1:0];
				mbss_pkg::REG_LIMIT:    limit_q    <= cfg_data[mbss_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign advance    = valid_s1 && (!out_valid_q || match_ready);
	assign byte_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			data_s1  <= data_byte;
			addr_s1  <= byte_address;
			first_s1 <= first_of_region;
		end
	end

	// newest byte first, then the window as cleared by a region start
	always_comb begin
		seq[0] = data_s1;
		for (int k = 1; k < mbss_pkg::PATTERN_BYTES; k++) begin
			seq[k] = first_s1 ? 8'd0 : win_q[k-1];
		end
	end

	assign mcfg.pattern = {pat_high_q, pat_low_q};
	assign mcfg.care    = care_q;
	assign mcfg.len     = mbss_pkg::eff_len(len_q);

	mbss_match u_match (
		.seq (seq),
		.cfg (mcfg),
		.hit (hit_raw)
	);

	assign fill_base = first_s1 ? '0 : fill_q;
	assign cnt_base  = first_s1 ? '0 : cnt_q;
	assign stop_base = first_s1 ? 1'b0 : stop_q;
	assign fill_ok   = (mbss_pkg::LEN_W'(fill_base) + mbss_pkg::LEN_W'(1)) >= mcfg.len;
	assign hit       = hit_raw && fill_ok && !stop_base;
	assign cnt_inc   = (cnt_base == '1) ? cnt_base : cnt_base + mbss_pkg::CNT_W'(1);
	assign at_limit  = (limit_q != '0) && (cnt_inc == limit_q);
	assign fill_next = (fill_base < mbss_pkg::FILL_W'(mbss_pkg::WIN_DEPTH)) ?
		fill_base + mbss_pkg::FILL_W'(1) : fill_base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= '0;
			fill_q <= '0;
			cnt_q  <= '0;
			stop_q <= 1'b0;
		end else if (advance) begin
			for (int k = 0; k < mbss_pkg::WIN_DEPTH; k++) begin
				win_q[k] <= seq[k];
			end
			fill_q <= fill_next;
			cnt_q  <= hit ? cnt_inc : cnt_base;
			stop_q <= hit ? (stop_base || at_limit) : stop_base;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= hit;
		end else if (match_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && hit) begin
			out_addr_q <= addr_s1 - mbss_pkg::ADDRESS_BITS'(mcfg.len - mbss_pkg::LEN_W'(1));
			out_num_q  <= cnt_inc;
			out_lim_q  <= at_limit;
		end
	end

	assign match_valid   = out_valid_q;
	assign match_address = out_addr_q;
	assign match_number  = out_num_q;
	assign limit_reached = out_lim_q;

`ifndef SYNTH
	a_num_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_num_q != '0))
		else $error("match item with zero ordinal");

	a_limit_num: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_lim_q) |-> (out_num_q == limit_q))
		else $error("limit flag on wrong ordinal");

	a_region_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && first_s1) |=> (fill_q == mbss_pkg::FILL_W'(1)))
		else $error("region start did not restart window fill");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_ready |-> (valid_s1 && out_valid_q && !match_ready))
		else $error("input stalled without a pending output");
`endif

endmodule
